// File: hdl/pidpc_pkg.sv
// shared types and constants of the pid position controller
`timescale 1ns / 1ps
`default_nettype none

package pidpc_pkg;

   // register indexes on the csr write channel
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_P        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_I        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET        = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_VOLTAGE_LIMIT = 3'd4;

   // field widths
   localparam int POS_WIDTH   = 32;
   localparam int ERR_WIDTH   = 33;
   localparam int DIFF_WIDTH  = 34;
   localparam int GAIN_WIDTH  = 32;
   localparam int LIMIT_WIDTH = 31;
   localparam int VOLT_WIDTH  = 32;

   // reset values
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_P_RESET     = 32'sd328;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_I_RESET     = 32'sd0;
   localparam logic signed [GAIN_WIDTH-1:0] GAIN_D_RESET     = 32'sd0;
   localparam logic signed [POS_WIDTH-1:0]  TARGET_RESET     = 32'sd0;
   localparam logic [LIMIT_WIDTH-1:0]       LIMIT_RESET      = 31'd786432;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // gains and clamp seen by the back end
   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] gain_p;
      logic signed [GAIN_WIDTH-1:0] gain_i;
      logic signed [GAIN_WIDTH-1:0] gain_d;
      logic [LIMIT_WIDTH-1:0]       voltage_limit;
   } gains_type;

endpackage

`default_nettype wire

// File: hdl/pid_position_controller.sv
// top level of the positional pid controller with output clamp
`timescale 1ns / 1ps
`default_nettype none

// Positional PID on encoder counts. Each req beat carries one measured position; the block
// forms error = target - position, a saturating error sum and the difference from the last
// error, and returns one rsp beat with kp*error + ki*sum + kd*difference in Q16.16, clamped to
// plus or minus voltage_limit. One item is taken every cycle while the front queue has room; a
// req beat passes the front queue, then the product, pair-add, rescale and clamp stages of
// the back pipeline. A four-entry queue lets req beats keep coming while the rsp side stalls.
// Writing target_position clears the error sum and the last error.
// Gains and the limit are written through the csr channel, which is always ready; write them
// only while no item is in flight.
module pid_position_controller
   import pidpc_pkg::*;
#(
   parameter int SUM_WIDTH      = 48,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [POS_WIDTH-1:0]       req_tdata,   // [31:0] measured_position
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [VOLT_WIDTH-1:0]      rsp_tdata,   // [31:0] drive_voltage
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                csr_data
);

   localparam int QW = ERR_WIDTH + DIFF_WIDTH + SUM_WIDTH;

   gains_type                     gains_ff, gains_in;
   logic signed [POS_WIDTH-1:0]   target_ff, target_in;
   logic                          csr_write;
   logic                          clear;

   logic                          q_ready;
   logic                          push;
   logic signed [ERR_WIDTH-1:0]   push_err;
   logic signed [DIFF_WIDTH-1:0]  push_diff;
   logic signed [SUM_WIDTH-1:0]   push_sum;
   logic                          q_valid;
   logic                          pop;
   logic [QW-1:0]                 q_data;

   // register writes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign clear     = csr_write && (csr_index == REG_TARGET);

   always_comb begin
      gains_in  = gains_ff;
      target_in = target_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_GAIN_P:        gains_in.gain_p        = $signed(csr_data);
            REG_GAIN_I:        gains_in.gain_i        = $signed(csr_data);
            REG_GAIN_D:        gains_in.gain_d        = $signed(csr_data);
            REG_TARGET:        target_in              = $signed(csr_data);
            REG_VOLTAGE_LIMIT: gains_in.voltage_limit = csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.gain_p        <= GAIN_P_RESET;
         gains_ff.gain_i        <= GAIN_I_RESET;
         gains_ff.gain_d        <= GAIN_D_RESET;
         gains_ff.voltage_limit <= LIMIT_RESET;
         target_ff              <= TARGET_RESET;
      end else begin
         gains_ff  <= gains_in;
         target_ff <= target_in;
      end
   end

   // front end
   pidpc_front #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .target     (target_ff),
      .clear      (clear),
      .q_ready    (q_ready),
      .push       (push),
      .push_err   (push_err),
      .push_diff  (push_diff),
      .push_sum   (push_sum)
   );

   // queue between front and back
   pidpc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_sum, push_diff, push_err}),
      .in_ready  (q_ready),
      .pop       (pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   // back end
   pidpc_back #(
      .SUM_WIDTH      (SUM_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .gains      (gains_ff),
      .q_valid    (q_valid),
      .pop        (pop),
      .q_err      ($signed(q_data[ERR_WIDTH-1:0])),
      .q_diff     ($signed(q_data[ERR_WIDTH+DIFF_WIDTH-1:ERR_WIDTH])),
      .q_sum      ($signed(q_data[QW-1:ERR_WIDTH+DIFF_WIDTH])),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hdl/pidpc_queue.sv
// short fifo between the front and the back of the controller
`timescale 1ns / 1ps
`default_nettype none

module pidpc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             in_ready,
   input  wire logic             pop,
   output      logic             out_valid,
   output      logic [WIDTH-1:0] out_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   logic [WIDTH-1:0]     entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill count never runs past the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   // fill count rises on a push without a pop
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   // no push into a full queue, no pop from an empty one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (!push || in_ready) && (!pop || out_valid))
      else $error("queue overrun or underrun");

endmodule

`default_nettype wire

// File: hdl/pidpc_front.sv
// front end: takes position beats, forms error, error sum and difference
`timescale 1ns / 1ps
`default_nettype none

module pidpc_front
   import pidpc_pkg::*;
#(
   parameter int SUM_WIDTH = 48
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [POS_WIDTH-1:0]        req_tdata,   // [31:0] measured_position
   input  wire logic signed [POS_WIDTH-1:0] target,
   input  wire logic                        clear,
   input  wire logic                        q_ready,
   output      logic                        push,
   output      logic signed [ERR_WIDTH-1:0] push_err,
   output      logic signed [DIFF_WIDTH-1:0] push_diff,
   output      logic signed [SUM_WIDTH-1:0] push_sum
);

   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic signed [ERR_WIDTH-1:0] prev_ff, prev_in;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_sat;

   assign req_tready = q_ready;
   assign push       = req_tvalid && q_ready;

   // error against the target and difference from the last error
   assign push_err  = ERR_WIDTH'(target) - ERR_WIDTH'($signed(req_tdata));
   assign push_diff = DIFF_WIDTH'(push_err) - DIFF_WIDTH'(prev_ff);

   // saturating error sum
   always_comb begin
      sum_wide = (SUM_WIDTH + 1)'(sum_ff) + (SUM_WIDTH + 1)'(push_err);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
   end
   assign push_sum = sum_sat;

   // state update, a target write clears the history
   always_comb begin
      sum_in  = sum_ff;
      prev_in = prev_ff;
      if (clear) begin
         sum_in  = '0;
         prev_in = '0;
      end else if (push) begin
         sum_in  = sum_sat;
         prev_in = push_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         prev_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         prev_ff <= prev_in;
      end
   end

   // a target write leaves a clean history
   a_clear_history: assert property (@(posedge clock) disable iff (reset)
      clear |=> (sum_ff == '0 && prev_ff == '0))
      else $error("history not cleared by target write");

endmodule

`default_nettype wire

// File: hdl/pidpc_back.sv
// back end: gain products, sum, rescale and output clamp
`timescale 1ns / 1ps
`default_nettype none

module pidpc_back
   import pidpc_pkg::*;
#(
   parameter int SUM_WIDTH      = 48,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire gains_type                    gains,
   input  wire logic                         q_valid,
   output      logic                         pop,
   input  wire logic signed [ERR_WIDTH-1:0]  q_err,
   input  wire logic signed [DIFF_WIDTH-1:0] q_diff,
   input  wire logic signed [SUM_WIDTH-1:0]  q_sum,
   output      logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   output      logic [VOLT_WIDTH-1:0]        rsp_tdata    // [31:0] drive_voltage
);

   localparam int PE_WIDTH = ERR_WIDTH + GAIN_WIDTH;
   localparam int PD_WIDTH = DIFF_WIDTH + GAIN_WIDTH;
   localparam int PL_WIDTH = 33 + GAIN_WIDTH;
   localparam int HI_WIDTH = SUM_WIDTH - 32;
   localparam int PH_WIDTH = SUM_WIDTH;
   localparam int TW       = SUM_WIDTH + 34;
   localparam int RW       = TW + 8;

   logic advance;

   logic                       s1_valid_ff;
   logic signed [PE_WIDTH-1:0] pe_ff, pe_in;
   logic signed [PD_WIDTH-1:0] pd_ff, pd_in;
   logic signed [PL_WIDTH-1:0] pl_ff, pl_in;
   logic signed [PH_WIDTH-1:0] ph_ff, ph_in;
   logic signed [HI_WIDTH-1:0] sum_hi;
   logic signed [32:0]         sum_lo;

   logic                       s2_valid_ff;
   logic signed [TW-1:0]       a_ff, a_in;
   logic signed [TW-1:0]       b_ff, b_in;

   logic                       s3_valid_ff;
   logic signed [RW-1:0]       total;
   logic signed [RW-1:0]       r_ff, r_in;

   logic                       out_valid_ff;
   logic [VOLT_WIDTH-1:0]      out_ff, out_in;
   logic signed [RW-1:0]       lim_pos;
   logic signed [RW-1:0]       lim_neg;
   logic [VOLT_WIDTH-1:0]      lim_word;

   // the whole pipe moves unless a result waits at the output
   assign advance    = !out_valid_ff || rsp_tready;
   assign pop        = q_valid && advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // stage 1: gain products, error sum split in a low and a high half
   assign sum_hi = q_sum[SUM_WIDTH-1:32];
   assign sum_lo = $signed({1'b0, q_sum[31:0]});
   assign pe_in  = q_err * gains.gain_p;
   assign pd_in  = q_diff * gains.gain_d;
   assign pl_in  = sum_lo * gains.gain_i;
   assign ph_in  = sum_hi * gains.gain_i;

   // stage 2: pair the products
   assign a_in = TW'(pe_ff) + TW'(pd_ff);
   assign b_in = TW'(pl_ff) + TW'($signed({ph_ff, 32'b0}));

   // stage 3: total and rescale to sixteen fraction bits
   assign total = RW'(a_ff) + RW'(b_ff);
   generate
      if (GAIN_FRAC_BITS > 16) begin : g_round
         localparam logic signed [RW-1:0] HALF = RW'(1) <<< (GAIN_FRAC_BITS - 17);
         assign r_in = (total + HALF) >>> (GAIN_FRAC_BITS - 16);
      end else if (GAIN_FRAC_BITS < 16) begin : g_widen
         assign r_in = total <<< (16 - GAIN_FRAC_BITS);
      end else begin : g_keep
         assign r_in = total;
      end
   endgenerate

   // output stage: clamp to the voltage limit
   assign lim_pos  = RW'($signed({1'b0, gains.voltage_limit}));
   assign lim_neg  = -lim_pos;
   assign lim_word = {1'b0, gains.voltage_limit};
   always_comb begin
      if (r_ff > lim_pos) begin
         out_in = lim_word;
      end else if (r_ff < lim_neg) begin
         out_in = -lim_word;
      end else begin
         out_in = r_ff[VOLT_WIDTH-1:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         pe_ff  <= pe_in;
         pd_ff  <= pd_in;
         pl_ff  <= pl_in;
         ph_ff  <= ph_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         r_ff   <= r_in;
         out_ff <= out_in;
      end
   end

   // a stalled output freezes the stages behind it
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> ($stable(s3_valid_ff) && $stable(s2_valid_ff)))
      else $error("pipe moved during output stall");

   // nothing leaves the queue while the pipe is stalled
   a_no_pop_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !pop)
      else $error("queue popped during output stall");

endmodule

`default_nettype wire
